>>> src/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// shared types and constants for the ps/2 mouse packet tracker
// ----------------------------------------------------------------------------
package ps2mt_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_MOUSE_KIND = 2'd0;
	localparam logic [1:0] CFG_X_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_Y_LIMIT    = 2'd2;

	localparam int unsigned CFG_DATA_BITS = 16;
	localparam int unsigned LIMIT_BITS    = 16;
	localparam int unsigned DELTA_BITS    = 10;

	// byte 0 flag bits
	localparam int unsigned SYNC_BIT  = 3;
	localparam int unsigned X_SIGN    = 4;
	localparam int unsigned Y_SIGN    = 5;
	localparam int unsigned X_OVF     = 6;
	localparam int unsigned Y_OVF     = 7;

	// button 4 and 5 bits of byte 3
	localparam int unsigned BTN4_BIT  = 4;
	localparam int unsigned BTN5_BIT  = 5;

	localparam logic signed [DELTA_BITS-1:0] DELTA_OVF_POS = 10'sd255;
	localparam logic signed [DELTA_BITS-1:0] DELTA_OVF_NEG = -10'sd255;

	// packet position of the last byte
	localparam logic [1:0] LAST_IDX_SHORT = 2'd2;
	localparam logic [1:0] LAST_IDX_LONG  = 2'd3;

	typedef enum logic [1:0] {
		KIND_GENERIC = 2'd0,
		KIND_WHEEL   = 2'd1,
		KIND_FIVE    = 2'd2
	} mouse_kind_t;

	// assembled packet handed to the update stage
	typedef struct packed {
		logic        done;
		mouse_kind_t kind;
		logic [7:0]  flags;
		logic [7:0]  dx;
		logic [7:0]  dy;
		logic [7:0]  last;
	} packet_t;

	// decoded result
	typedef struct packed {
		logic [15:0]        x_position;
		logic [15:0]        y_position;
		logic signed [15:0] wheel_total;
		logic               left_button;
		logic               right_button;
		logic               middle_button;
		logic               fourth_button;
		logic               fifth_button;
	} result_t;

endpackage

>>> src/ps2_mouse_packet_tracker_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// decodes ps/2 mouse packets into clamped positions, wheel total and buttons
// ----------------------------------------------------------------------------
// usage
// - input channel: one mouse byte per word on rx_byte, in_valid / in_ready
// - output channel: one word per finished packet, out_valid / out_ready
// - generic mice send 3-byte packets, wheel and five-button mice 4-byte
//   packets; a byte without the sync bit is dropped between packets
// - config port: cfg_write with cfg_index / cfg_data;
//   write only while the block is idle
// timing
// - a byte is registered at acceptance and decoded in the next cycle; the
//   result of a packet's last byte is registered when that byte leaves the input register
// - one byte per cycle sustained unless a packet's last byte waits on the
//   result register; the decode from input to result register sets the rate
// reset
// - counters, accumulators and the output valid clear; limits go to all ones
//   and the mouse kind to generic
// stall
// - while a result waits, bytes that do not end a packet keep flowing; the
//   byte that ends the next packet waits in the input register
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top
	import ps2mt_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// config port
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// byte input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        x_position,
	output logic [15:0]        y_position,
	output logic signed [15:0] wheel_total,
	output logic               left_button,
	output logic               right_button,
	output logic               middle_button,
	output logic               fourth_button,
	output logic               fifth_button
);

	// config registers
	logic [1:0]            mouse_kind_q;
	logic [LIMIT_BITS-1:0] x_limit_q;
	logic [LIMIT_BITS-1:0] y_limit_q;
	mouse_kind_t           kind;

	// input stage
	logic                  valid_s1;
	logic [7:0]            rx_byte_s1;
	logic                  advance;
	logic                  commit;

	packet_t               pkt;
	result_t               res;
	result_t               res_q;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_kind_q <= KIND_GENERIC;
			x_limit_q    <= '1;
			y_limit_q    <= '1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MOUSE_KIND: mouse_kind_q <= cfg_data[1:0];
				CFG_X_LIMIT:    x_limit_q    <= cfg_data;
				CFG_Y_LIMIT:    y_limit_q    <= cfg_data;
				default:        ;
			endcase
		end
	end

	// unused kind code decodes as generic
	always_comb begin
		case (mouse_kind_q)
			KIND_WHEEL: kind = KIND_WHEEL;
			KIND_FIVE:  kind = KIND_FIVE;
			default:    kind = KIND_GENERIC;
		endcase
	end

	// a byte that finishes no packet always moves on; a finishing byte needs
	// the result register free or emptying this cycle
	assign advance  = valid_s1 && (!pkt.done || !out_valid_q || out_ready);
	assign commit   = advance && pkt.done;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ps2mt_assembler u_assembler (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte_s1 (rx_byte_s1),
		.advance    (advance),
		.kind       (kind),
		.pkt        (pkt)
	);

	ps2mt_update #(
		.POSITION_BITS (POSITION_BITS)
	) u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.commit  (commit),
		.x_limit (x_limit_q),
		.y_limit (y_limit_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign x_position    = res_q.x_position;
	assign y_position    = res_q.y_position;
	assign wheel_total   = res_q.wheel_total;
	assign left_button   = res_q.left_button;
	assign right_button  = res_q.right_button;
	assign middle_button = res_q.middle_button;
	assign fourth_button = res_q.fourth_button;
	assign fifth_button  = res_q.fifth_button;

endmodule

>>> src/ps2mt_assembler.sv
// ----------------------------------------------------------------------------
// ps2mt_assembler
// byte counter and packet byte store; flags the byte that ends a packet
// ----------------------------------------------------------------------------
module ps2mt_assembler
	import ps2mt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte_s1,
	input  logic        advance,
	input  mouse_kind_t kind,
	output packet_t     pkt
);

	logic [1:0] byte_index_q;
	logic [7:0] packet_bytes_q [3];
	logic [1:0] last_idx;
	logic       drop;
	logic       gather;
	logic       short_end;

	assign last_idx  = (kind == KIND_GENERIC) ? LAST_IDX_SHORT : LAST_IDX_LONG;
	// idle and no sync bit: byte cannot open a packet
	assign drop      = (byte_index_q == 2'd0) && !rx_byte_s1[SYNC_BIT];
	assign gather    = !drop && (byte_index_q < last_idx);
	assign short_end = (kind == KIND_GENERIC) && (byte_index_q == LAST_IDX_SHORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= 2'd0;
		end else if (advance && !drop) begin
			byte_index_q <= gather ? byte_index_q + 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gather) begin
			packet_bytes_q[byte_index_q] <= rx_byte_s1;
		end
	end

	always_comb begin
		pkt.done  = !drop && !gather;
		pkt.kind  = kind;
		pkt.flags = packet_bytes_q[0];
		pkt.dx    = packet_bytes_q[1];
		pkt.dy    = short_end ? rx_byte_s1 : packet_bytes_q[2];
		pkt.last  = rx_byte_s1;
	end

endmodule

>>> src/ps2mt_update.sv
// ----------------------------------------------------------------------------
// ps2mt_update
// position and wheel accumulators; computes the result of a finished packet
// ----------------------------------------------------------------------------
module ps2mt_update
	import ps2mt_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  packet_t                pkt,
	input  logic                   commit,
	input  logic [LIMIT_BITS-1:0]  x_limit,
	input  logic [LIMIT_BITS-1:0]  y_limit,
	output result_t                res
);

	localparam int unsigned AW = (POSITION_BITS < LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS;
	localparam int unsigned SW = AW + 2;
	localparam logic [LIMIT_BITS-1:0] POS_CAP = LIMIT_BITS'((64'd1 << AW) - 64'd1);

	logic [AW-1:0]             x_accum_q;
	logic [AW-1:0]             y_accum_q;
	logic signed [15:0]        wheel_accum_q;
	logic [AW-1:0]             x_next;
	logic [AW-1:0]             y_next;
	logic signed [15:0]        wheel_next;
	logic signed [15:0]        wheel_delta;
	logic signed [DELTA_BITS-1:0] dx;
	logic signed [DELTA_BITS-1:0] dy;
	logic [LIMIT_BITS-1:0]     x_lim16;
	logic [LIMIT_BITS-1:0]     y_lim16;
	logic                      five;

	function automatic logic signed [DELTA_BITS-1:0] axis_delta(
		input logic [7:0] mag,
		input logic       neg,
		input logic       ovf
	);
		logic signed [DELTA_BITS-1:0] d;
		if (ovf) begin
			d = neg ? DELTA_OVF_NEG : DELTA_OVF_POS;
		end else begin
			d = $signed({neg, neg, mag});
		end
		return d;
	endfunction

	function automatic logic [AW-1:0] move_clamped(
		input logic [AW-1:0]                 pos,
		input logic signed [DELTA_BITS-1:0]  d,
		input logic [AW-1:0]                 lim
	);
		logic signed [SW-1:0] sum;
		logic [AW-1:0]        r;
		sum = $signed({2'b00, pos}) + SW'(d);
		if (sum[SW-1]) begin
			r = '0;
		end else if (sum > $signed({2'b00, lim})) begin
			r = lim;
		end else begin
			r = sum[AW-1:0];
		end
		return r;
	endfunction

	assign x_lim16 = (x_limit > POS_CAP) ? POS_CAP : x_limit;
	assign y_lim16 = (y_limit > POS_CAP) ? POS_CAP : y_limit;

	assign dx = axis_delta(pkt.dx, pkt.flags[X_SIGN], pkt.flags[X_OVF]);
	assign dy = axis_delta(pkt.dy, pkt.flags[Y_SIGN], pkt.flags[Y_OVF]);

	assign x_next = move_clamped(x_accum_q, dx, x_lim16[AW-1:0]);
	assign y_next = move_clamped(y_accum_q, dy, y_lim16[AW-1:0]);

	always_comb begin
		case (pkt.kind)
			KIND_WHEEL: wheel_delta = 16'($signed(pkt.last));
			KIND_FIVE:  wheel_delta = 16'($signed(pkt.last[3:0]));
			default:    wheel_delta = '0;
		endcase
	end

	assign wheel_next = wheel_accum_q + wheel_delta;
	assign five       = (pkt.kind == KIND_FIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_accum_q     <= '0;
			y_accum_q     <= '0;
			wheel_accum_q <= '0;
		end else if (commit) begin
			x_accum_q     <= x_next;
			y_accum_q     <= y_next;
			wheel_accum_q <= wheel_next;
		end
	end

	always_comb begin
		res.x_position    = 16'(x_next);
		res.y_position    = 16'(y_next);
		res.wheel_total   = wheel_next;
		res.left_button   = pkt.flags[0];
		res.right_button  = pkt.flags[1];
		res.middle_button = pkt.flags[2];
		res.fourth_button = five && pkt.last[BTN4_BIT];
		res.fifth_button  = five && pkt.last[BTN5_BIT];
	end

endmodule
